>>> src/gals_pkg.sv
// gals_pkg: shared constants, codes and structs for the graph adjacency list store.
// No dependencies; compiled first.
package gals_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam int VID_W  = $clog2(MAX_VERTICES);
  localparam int DEG_W  = $clog2(MAX_DEGREE);
  localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
  localparam int ADDR_W = VID_W + DEG_W;
  localparam int VC_W   = 7;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEGREE);

  // operation codes
  localparam logic [2:0] MODE_ADD_UNDIR = 3'd0;
  localparam logic [2:0] MODE_ADD_DIR   = 3'd1;
  localparam logic [2:0] MODE_REMOVE    = 3'd2;
  localparam logic [2:0] MODE_QUERY     = 3'd3;
  localparam logic [2:0] MODE_READ      = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [2:0]                    status;
    logic                          edge_found;
    logic                          neighbor_valid;
    logic [VID_W-1:0]              neighbor_id;
    logic signed [WEIGHT_BITS-1:0] neighbor_weight;
    logic                          last;
  } out_word_t;

  typedef struct packed {
    logic       load_in;
    logic       cnt_rd;
    logic       cnt_rd_t;
    logic       cnt_lat;
    logic       scan_clr;
    logic       scan_step;
    logic       set_phase;
    logic       mv_rd;
    logic       mv_wr;
    logic       app1;
    logic       app2;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_found;
    logic       out_nbr;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       in_ok;
    logic       self_loop;
    logic       hit;
    logic       found;
    logic       pend;
    logic       scan_done;
    logic       cnt_zero;
    logic       full_s;
    logic       full_t;
    logic       full_s2;
    logic       phase;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> src/gals_in_if.sv
// gals_in_if: input channel carrying one operation word.
// Depends on gals_pkg.
interface gals_in_if import gals_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    mode;
  logic [VID_W-1:0]              source_vertex;
  logic [VID_W-1:0]              target_vertex;
  logic signed [WEIGHT_BITS-1:0] edge_weight;

  modport source (output valid, mode, source_vertex, target_vertex, edge_weight,
                  input ready);
  modport sink   (input valid, mode, source_vertex, target_vertex, edge_weight,
                  output ready);
endinterface

>>> src/gals_out_if.sv
// gals_out_if: result channel, one result word per handshake.
// Depends on gals_pkg.
interface gals_out_if import gals_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic                          edge_found;
  logic                          neighbor_valid;
  logic [VID_W-1:0]              neighbor_id;
  logic signed [WEIGHT_BITS-1:0] neighbor_weight;
  logic                          last;

  modport source (output valid, status, edge_found, neighbor_valid, neighbor_id,
                  neighbor_weight, last, input ready);
  modport sink   (input valid, status, edge_found, neighbor_valid, neighbor_id,
                  neighbor_weight, last, output ready);
endinterface

>>> src/graph_adjacency_list_store_top.sv
// Weighted graph adjacency list store: 64 vertices, 16 (id, weight) slots each.
// One operation word at a time: ready only when idle. An undirected removal
// makes two linear scans, one entry a cycle, plus move-last and count updates;
// a list read hands out each entry before it fetches the next. Sync reset
// clears all counts at once; no sweep.
module graph_adjacency_list_store_top import gals_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [VC_W-1:0]   cfg_wr_data,
  gals_in_if.sink           in_ch,
  gals_out_if.source        out_ch
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t ow;

  // sequencer: walks each operation through count read, scan, move, append or read
  gals_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: memories, scan compare and the result word register
  gals_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (in_ch.mode),
    .in_src      (in_ch.source_vertex),
    .in_tgt      (in_ch.target_vertex),
    .in_wt       (in_ch.edge_weight),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_word    (ow)
  );

  assign out_ch.status          = ow.status;
  assign out_ch.edge_found      = ow.edge_found;
  assign out_ch.neighbor_valid  = ow.neighbor_valid;
  assign out_ch.neighbor_id     = ow.neighbor_id;
  assign out_ch.neighbor_weight = ow.neighbor_weight;
  assign out_ch.last            = ow.last;

endmodule

>>> src/gals_datapath.sv
// gals_datapath: operand registers, count and neighbour memories, scan logic,
// output register. Depends on gals_pkg; driven by gals_ctrl.
module gals_datapath import gals_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [VC_W-1:0]               cfg_wr_data,
  input  logic [2:0]                    in_mode,
  input  logic [VID_W-1:0]              in_src,
  input  logic [VID_W-1:0]              in_tgt,
  input  logic signed [WEIGHT_BITS-1:0] in_wt,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output out_word_t                     out_word
);

  logic [VC_W-1:0]        vc;
  logic [2:0]             mode;
  logic [VID_W-1:0]       src, tgt;
  logic [WEIGHT_BITS-1:0] wt;
  logic                   phase;
  logic [CNT_W-1:0]       cs, ct, cnt_q;
  logic [CNT_W-1:0]       idx;
  logic                   pend, found;
  logic [DEG_W-1:0]       fidx;
  logic [VID_W-1:0]       rd_id;
  logic [WEIGHT_BITS-1:0] rd_wt;

  logic [VID_W+WEIGHT_BITS-1:0] tbl [MAX_VERTICES*MAX_DEGREE];
  logic [CNT_W-1:0]             cnt_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]      cnt_vld;

  logic [CNT_W-1:0] cc, cc_m1;
  logic [VID_W-1:0] cv, ck;
  logic             hit;

  logic                         tbl_we, tbl_re;
  logic [ADDR_W-1:0]            tbl_wa, tbl_ra;
  logic [VID_W+WEIGHT_BITS-1:0] tbl_wd;
  logic                         cnt_we;
  logic [VID_W-1:0]             cnt_wa, cnt_ra;
  logic [CNT_W-1:0]             cnt_wd;

  assign cc    = phase ? ct : cs;
  assign cc_m1 = cc - CNT_W'(1);
  assign cv    = phase ? tgt : src;
  assign ck    = phase ? src : tgt;
  assign hit   = pend && (rd_id == ck);

  always_comb begin
    stat.mode      = mode;
    stat.in_ok     = ({1'b0, src} < vc) && ((mode == MODE_READ) || ({1'b0, tgt} < vc));
    stat.self_loop = (src == tgt);
    stat.hit       = hit;
    stat.found     = found;
    stat.pend      = pend;
    stat.scan_done = (idx >= cc);
    stat.cnt_zero  = (cc == '0);
    stat.full_s    = (cs >= CNT_MAX);
    stat.full_t    = (ct >= CNT_MAX);
    stat.full_s2   = ((CNT_W+1)'(cs) + (CNT_W+1)'(2) > (CNT_W+1)'(MAX_DEGREE));
    stat.phase     = phase;
    stat.out_free  = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = {cv, fidx};
    tbl_wd = {rd_id, rd_wt};
    cnt_we = 1'b0;
    cnt_wa = cv;
    cnt_wd = cc_m1;
    priority if (cmd.mv_wr) begin
      tbl_we = 1'b1;
      cnt_we = 1'b1;
    end else if (cmd.app1) begin
      tbl_we = 1'b1;
      tbl_wa = {src, cs[DEG_W-1:0]};
      tbl_wd = {tgt, wt};
      cnt_we = 1'b1;
      cnt_wa = src;
      cnt_wd = ((mode == MODE_ADD_UNDIR) && (src == tgt)) ? cs + CNT_W'(2) : cs + CNT_W'(1);
    end else if (cmd.app2) begin
      tbl_we = 1'b1;
      tbl_wd = {src, wt};
      if (src == tgt) begin
        tbl_wa = {src, cs[DEG_W-1:0] + DEG_W'(1)};
      end else begin
        tbl_wa = {tgt, ct[DEG_W-1:0]};
        cnt_we = 1'b1;
        cnt_wa = tgt;
        cnt_wd = ct + CNT_W'(1);
      end
    end
    tbl_re = cmd.scan_step || cmd.mv_rd;
    tbl_ra = cmd.mv_rd ? {cv, cc_m1[DEG_W-1:0]} : {cv, idx[DEG_W-1:0]};
    cnt_ra = cmd.cnt_rd_t ? tgt : src;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      {rd_id, rd_wt} <= tbl[tbl_ra];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.cnt_rd) begin
      cnt_q <= cnt_vld[cnt_ra] ? cnt_mem[cnt_ra] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[cnt_wa] <= 1'b1;
    end
  end

  // operand and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vc    <= VC_RESET;
      phase <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vc <= cfg_wr_data;
      end
      if (cmd.load_in) begin
        phase <= 1'b0;
      end else if (cmd.set_phase) begin
        phase <= 1'b1;
      end
      pend <= cmd.scan_step;
      if (cmd.scan_clr) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode <= in_mode;
      src  <= in_src;
      tgt  <= in_tgt;
      wt   <= in_wt;
    end
    if (cmd.cnt_lat) begin
      if (phase) begin
        ct <= cnt_q;
      end else begin
        cs <= cnt_q;
      end
    end
    if (cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + CNT_W'(1);
    end
    if (hit && !found) begin
      fidx <= rd_id == ck ? DEG_W'(idx - CNT_W'(1)) : fidx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.status          <= cmd.out_status;
      out_word.edge_found      <= cmd.out_found;
      out_word.neighbor_valid  <= cmd.out_nbr;
      out_word.neighbor_id     <= cmd.out_nbr ? rd_id : '0;
      out_word.neighbor_weight <= cmd.out_nbr ? rd_wt : '0;
      out_word.last            <= cmd.out_last;
    end
  end

endmodule

>>> src/gals_ctrl.sv
// gals_ctrl: operation sequencer for the adjacency list store.
// Depends on gals_pkg; steers gals_datapath through dp_cmd_t / dp_stat_t.
module gals_ctrl import gals_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_CHECK    = 13'b0000000000010,
    S_CNT_LAT  = 13'b0000000000100,
    S_SCAN     = 13'b0000000001000,
    S_MV_RD    = 13'b0000000010000,
    S_MV_WR    = 13'b0000000100000,
    S_SIDE2    = 13'b0000001000000,
    S_FULL_CHK = 13'b0000010000000,
    S_APP1     = 13'b0000100000000,
    S_APP2     = 13'b0001000000000,
    S_RD_ISS   = 13'b0010000000000,
    S_RD_OUT   = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] rsp_status, rsp_status_next;
  logic       rsp_found, rsp_found_next;
  logic       miss, miss_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    rsp_status_next = rsp_status;
    rsp_found_next  = rsp_found;
    miss_next       = miss;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in     = 1'b1;
          rsp_status_next = ST_OK;
          rsp_found_next  = 1'b0;
          miss_next       = 1'b0;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.mode > MODE_READ) begin
          state_next = S_RESP;
        end else if (!stat.in_ok) begin
          rsp_status_next = ST_INVALID;
          state_next      = S_RESP;
        end else begin
          cmd.cnt_rd = 1'b1;
          state_next = S_CNT_LAT;
        end
      end
      S_CNT_LAT: begin
        cmd.cnt_lat  = 1'b1;
        cmd.scan_clr = 1'b1;
        if (stat.mode == MODE_READ) begin
          state_next = S_RD_ISS;
        end else if (stat.phase && (stat.mode == MODE_ADD_UNDIR)) begin
          state_next = S_FULL_CHK;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.found || stat.hit) begin
          priority if (stat.mode == MODE_REMOVE) begin
            state_next = S_MV_RD;
          end else if (stat.mode == MODE_QUERY) begin
            rsp_found_next = 1'b1;
            state_next     = S_RESP;
          end else begin
            rsp_status_next = ST_EXISTS;
            state_next      = S_RESP;
          end
        end else if (!stat.pend && stat.scan_done) begin
          priority if (stat.mode == MODE_QUERY) begin
            state_next = S_RESP;
          end else if (stat.mode == MODE_REMOVE) begin
            miss_next = 1'b1;
            if (stat.phase) begin
              rsp_status_next = ST_NOT_FOUND;
              state_next      = S_RESP;
            end else begin
              state_next = S_SIDE2;
            end
          end else if (stat.mode == MODE_ADD_DIR) begin
            if (stat.full_s) begin
              rsp_status_next = ST_FULL;
              state_next      = S_RESP;
            end else begin
              state_next = S_APP1;
            end
          end else if (stat.self_loop) begin
            if (stat.full_s2) begin
              rsp_status_next = ST_FULL;
              state_next      = S_RESP;
            end else begin
              state_next = S_APP1;
            end
          end else begin
            state_next = S_SIDE2;
          end
        end else if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MV_RD: begin
        cmd.mv_rd  = 1'b1;
        state_next = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        if (stat.phase) begin
          rsp_status_next = miss ? ST_NOT_FOUND : ST_OK;
          state_next      = S_RESP;
        end else begin
          state_next = S_SIDE2;
        end
      end
      S_SIDE2: begin
        cmd.set_phase = 1'b1;
        cmd.cnt_rd    = 1'b1;
        cmd.cnt_rd_t  = 1'b1;
        state_next    = S_CNT_LAT;
      end
      S_FULL_CHK: begin
        if (stat.full_s || stat.full_t) begin
          rsp_status_next = ST_FULL;
          state_next      = S_RESP;
        end else begin
          state_next = S_APP1;
        end
      end
      S_APP1: begin
        cmd.app1   = 1'b1;
        state_next = (stat.mode == MODE_ADD_DIR) ? S_RESP : S_APP2;
      end
      S_APP2: begin
        cmd.app2   = 1'b1;
        state_next = S_RESP;
      end
      S_RD_ISS: begin
        if (stat.cnt_zero) begin
          state_next = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_nbr    = 1'b1;
          cmd.out_last   = stat.scan_done;
          state_next     = stat.scan_done ? S_IDLE : S_RD_ISS;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = rsp_status;
          cmd.out_found  = rsp_found;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_status <= rsp_status_next;
    rsp_found  <= rsp_found_next;
    miss       <= miss_next;
  end

endmodule

>>> src/gals_checker.sv
// gals_checker: port-level assertions for the store, bound to the top level.
// Depends on gals_pkg.
module gals_checker import gals_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic             edge_found,
  input logic             neighbor_valid,
  input logic [VID_W-1:0] neighbor_id,
  input logic             last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(neighbor_id) && $stable(status))
    else $error("result word dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while an operation is in flight");

  a_nonlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> neighbor_valid && (status == ST_OK))
    else $error("non-final result that is not a neighbour entry");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_found |-> (status == ST_OK) && last && !neighbor_valid)
    else $error("edge_found on a result that is not a query answer");

endmodule

bind graph_adjacency_list_store_top gals_checker u_gals_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .edge_found     (out_ch.edge_found),
  .neighbor_valid (out_ch.neighbor_valid),
  .neighbor_id    (out_ch.neighbor_id),
  .last           (out_ch.last)
);

>>> bench/graph_adjacency_list_store_top_tb.sv
// Testbench for graph_adjacency_list_store_top: directed and random graph operations,
// predicted by a scoreboard class holding its own copy of the adjacency lists.
// Depends on gals_pkg, gals_in_if, gals_out_if and the block itself.
module graph_adjacency_list_store_top_tb;
  import gals_pkg::*;

  // expected result word, in the block's own field widths
  typedef struct {
    logic [2:0]                    status;
    logic                          edge_found;
    logic                          neighbor_valid;
    logic [VID_W-1:0]              neighbor_id;
    logic signed [WEIGHT_BITS-1:0] neighbor_weight;
    logic                          last;
  } result_word_t;

  // Shadow graph: per-vertex lists plus the vertex count in force.
  class graph_scoreboard;
    int unsigned                   degree[MAX_VERTICES];
    logic [VID_W-1:0]              nbr_id[MAX_VERTICES][MAX_DEGREE];
    logic signed [WEIGHT_BITS-1:0] nbr_wt[MAX_VERTICES][MAX_DEGREE];
    int unsigned                   vertices_in_use;
    result_word_t                  pending_results[$];
    int                            errors;
    int                            words_checked;

    function void clear_graph();
      foreach (degree[v]) degree[v] = 0;
      vertices_in_use = MAX_VERTICES;
      pending_results.delete();
      errors = 0;
      words_checked = 0;
    endfunction

    function void set_vertex_count(logic [VC_W-1:0] vc);
      vertices_in_use = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
    endfunction

    function int find_slot(int v, int t);
      for (int i = 0; i < degree[v]; i++)
        if (nbr_id[v][i] == t) return i;
      return -1;
    endfunction

    function bit drop_neighbour(int v, int t);
      int i;
      i = find_slot(v, t);
      if (i < 0) return 0;
      degree[v]--;
      nbr_id[v][i] = nbr_id[v][degree[v]];
      nbr_wt[v][i] = nbr_wt[v][degree[v]];
      return 1;
    endfunction

    function void append_neighbour(int v, int t, logic signed [WEIGHT_BITS-1:0] w);
      nbr_id[v][degree[v]] = t;
      nbr_wt[v][degree[v]] = w;
      degree[v]++;
    endfunction

    function void push_status(logic [2:0] st, logic found);
      result_word_t r;
      r = '{st, found, 1'b0, '0, '0, 1'b1};
      pending_results.push_back(r);
    endfunction

    // one accepted operation word -> expected result words
    function void note_operation(logic [2:0] mode, int s, int t,
                                 logic signed [WEIGHT_BITS-1:0] w);
      bit a;
      bit b;
      result_word_t r;
      if (mode > MODE_READ) begin
        push_status(ST_OK, 0);
        return;
      end
      if (!(s < vertices_in_use && (mode == MODE_READ || t < vertices_in_use))) begin
        push_status(ST_INVALID, 0);
        return;
      end
      case (mode)
        MODE_ADD_UNDIR, MODE_ADD_DIR: begin
          if (find_slot(s, t) >= 0) push_status(ST_EXISTS, 0);
          else if (mode == MODE_ADD_DIR) begin
            if (degree[s] >= MAX_DEGREE) push_status(ST_FULL, 0);
            else begin
              append_neighbour(s, t, w);
              push_status(ST_OK, 0);
            end
          end else if (s == t) begin
            if (degree[s] + 2 > MAX_DEGREE) push_status(ST_FULL, 0);
            else begin
              append_neighbour(s, t, w);
              append_neighbour(s, s, w);
              push_status(ST_OK, 0);
            end
          end else begin
            if (degree[s] >= MAX_DEGREE || degree[t] >= MAX_DEGREE) push_status(ST_FULL, 0);
            else begin
              append_neighbour(s, t, w);
              append_neighbour(t, s, w);
              push_status(ST_OK, 0);
            end
          end
        end
        MODE_REMOVE: begin
          a = drop_neighbour(s, t);
          b = drop_neighbour(t, s);
          push_status((a && b) ? ST_OK : ST_NOT_FOUND, 0);
        end
        MODE_QUERY: push_status(ST_OK, find_slot(s, t) >= 0);
        default: begin
          if (degree[s] == 0) push_status(ST_OK, 0);
          else for (int i = 0; i < degree[s]; i++) begin
            r = '{ST_OK, 1'b0, 1'b1, nbr_id[s][i], nbr_wt[s][i], i + 1 == degree[s]};
            pending_results.push_back(r);
          end
        end
      endcase
    endfunction

    function void check_result(result_word_t got);
      result_word_t exp;
      words_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word, status %0d", got.status);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.edge_found !== exp.edge_found) begin
        $error("edge_found: expected %0d, got %0d", exp.edge_found, got.edge_found); errors++;
      end
      if (got.neighbor_valid !== exp.neighbor_valid) begin
        $error("neighbor_valid: expected %0d, got %0d", exp.neighbor_valid,
               got.neighbor_valid); errors++;
      end
      if (got.neighbor_id !== exp.neighbor_id) begin
        $error("neighbor_id: expected %0d, got %0d", exp.neighbor_id, got.neighbor_id);
        errors++;
      end
      if (got.neighbor_weight !== exp.neighbor_weight) begin
        $error("neighbor_weight: expected %0d, got %0d", exp.neighbor_weight,
               got.neighbor_weight); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [VC_W-1:0] cfg_wr_data = '0;

  gals_in_if  in_ch ();
  gals_out_if out_ch ();

  graph_adjacency_list_store_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  graph_scoreboard sb = new();
  int  idle_cycles = 0;
  int  words_sent = 0;
  bit  long_hold = 0;      // receiver held off by the pressure phase
  bit  stall_enable = 0;   // random receiver stalls on or off

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.source_vertex = '0;
    in_ch.target_vertex = '0;
    in_ch.edge_weight = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  // Checking happens at the edge, so sampled values are the settled ones.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.status, out_ch.edge_found, out_ch.neighbor_valid,
                        out_ch.neighbor_id, out_ch.neighbor_weight, out_ch.last});
    if (rst || long_hold) out_ch.ready <= 1'b0;
    else if (stall_enable) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("[graph_adjacency_list_store_top] ERROR");
      $finish;
    end
  end

  // Offer one operation word and hold it until accepted; note it in the shadow graph.
  task automatic send_op(logic [2:0] mode, logic [VID_W-1:0] s, logic [VID_W-1:0] t,
                         logic signed [WEIGHT_BITS-1:0] w);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.source_vertex <= s;
    in_ch.target_vertex <= t;
    in_ch.edge_weight <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operation(mode, s, t, w);
    words_sent++;
  endtask

  // Lower valid after a word; the caller may idle afterwards.
  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every predicted result has come back, plus a margin with
  // valid low before the next phase.
  task automatic wait_drained();
    drop_valid();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VC_W-1:0] vc);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= vc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_vertex_count(vc);
  endtask

  // Random operation mostly within a small vertex pool so lists fill and repeat.
  task automatic send_random_op(int pool);
    int r;
    logic [2:0] mode;
    r = $urandom_range(0, 99);
    if (r < 30) mode = MODE_ADD_UNDIR;
    else if (r < 50) mode = MODE_ADD_DIR;
    else if (r < 65) mode = MODE_REMOVE;
    else if (r < 80) mode = MODE_QUERY;
    else if (r < 95) mode = MODE_READ;
    else mode = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0)
      send_op(mode, 6'($urandom), 6'($urandom), 16'($urandom));
    else
      send_op(mode, 6'($urandom_range(0, pool - 1)), 6'($urandom_range(0, pool - 1)),
              16'($urandom));
  endtask

  // Bursty sender: random burst lengths, random gaps between bursts.
  task automatic random_phase(int count, int pool);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        send_random_op(pool);
        burst--;
        count--;
      end
      drop_valid();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  int vc_settings[4] = '{64, 1, 7, 127};

  initial begin
    sb.clear_graph();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: full-range vertex count, extremes and corner cases.
    send_op(MODE_READ, 6'd0, 6'd0, 16'sd0);                // empty read
    send_op(MODE_ADD_UNDIR, 6'd0, 6'd63, -16'sd32768);
    send_op(MODE_ADD_UNDIR, 6'd63, 6'd0, 16'sd32767);      // duplicate
    send_op(MODE_ADD_UNDIR, 6'd5, 6'd5, 16'sd1234);        // self-loop
    send_op(MODE_READ, 6'd5, 6'd0, 16'sd0);
    send_op(MODE_ADD_DIR, 6'd1, 6'd2, 16'sd32767);
    send_op(MODE_QUERY, 6'd1, 6'd2, 16'sd0);
    send_op(MODE_QUERY, 6'd2, 6'd1, 16'sd0);
    send_op(MODE_REMOVE, 6'd1, 6'd2, 16'sd0);              // partial removal
    send_op(MODE_REMOVE, 6'd5, 6'd5, 16'sd0);              // self-loop removal
    send_op(MODE_REMOVE, 6'd0, 6'd63, 16'sd0);
    send_op(3'd5, 6'd0, 6'd0, 16'sd0);                     // unused modes
    send_op(3'd7, 6'd63, 6'd63, -16'sd1);
    // fill vertex 3 to its limit, then overflow both directions
    for (int i = 0; i < MAX_DEGREE; i++)
      send_op(MODE_ADD_DIR, 6'd3, 6'(10 + i), 16'(i * 4099));
    send_op(MODE_ADD_DIR, 6'd3, 6'd40, 16'sd7);            // list full
    send_op(MODE_ADD_UNDIR, 6'd41, 6'd3, 16'sd7);          // other side full
    send_op(MODE_READ, 6'd3, 6'd0, 16'sd0);                // longest read
    wait_drained();

    // Pressure: receiver held off while the sender keeps offering words.
    long_hold = 1;
    fork
      begin
        for (int i = 0; i < 12; i++) send_random_op(8);
        drop_valid();
        @(posedge clk);
      end
      begin
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
    join
    wait_drained();

    // Random phases under several vertex counts, extremes among them.
    stall_enable = 1;
    foreach (vc_settings[k]) begin
      write_vertex_count(VC_W'(vc_settings[k]));
      random_phase(15, (vc_settings[k] < 8) ? 8 : 12);
      wait_drained();
      stall_enable = (k % 2 == 0);
    end
    write_vertex_count(7'd0);  // every vertex invalid
    random_phase(6, 12);
    wait_drained();

    $display("covered %0d operation words, %0d result words, vertex counts 0 to 127",
             words_sent, sb.words_checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("[graph_adjacency_list_store_top] OK");
    else
      $display("[graph_adjacency_list_store_top] ERROR");
    $finish;
  end
endmodule

>>> graph_adjacency_list_store_top.f
src/gals_pkg.sv
src/gals_in_if.sv
src/gals_out_if.sv
src/gals_datapath.sv
src/gals_ctrl.sv
src/graph_adjacency_list_store_top.sv
src/gals_checker.sv
bench/graph_adjacency_list_store_top_tb.sv
